// ===== rtl/fmbq_pkg.sv =====
// fmbq_pkg: shared types and constants of the front-middle-back queue
// used by the interfaces, the controller, the datapath and the checker
package fmbq_pkg;

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;

    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_MIDDLE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POP_MIDDLE  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_POP_BACK    = 3'd5;

    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd2;

    typedef struct packed {
        logic accept;
        logic exec;
    } t_dp_cmd;

endpackage

// ===== rtl/fmbq_req_if.sv =====
// fmbq_req_if: request channel, valid/ready handshake with request payload
// depends on fmbq_pkg
interface fmbq_req_if;
    logic                         valid;
    logic                         ready;
    logic [fmbq_pkg::REQ_W-1:0]   req_type;
    logic [fmbq_pkg::VALUE_W-1:0] push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

// ===== rtl/fmbq_rsp_if.sv =====
// fmbq_rsp_if: response channel, valid/ready handshake with result payload
// depends on fmbq_pkg
interface fmbq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fmbq_pkg::VALUE_W-1:0]  pop_value;
    logic [fmbq_pkg::STATUS_W-1:0] status;
    logic [fmbq_pkg::COUNT_W-1:0]  item_count;

    modport source (output valid, output pop_value, output status, output item_count,
                    input ready);
    modport sink   (input valid, input pop_value, input status, input item_count,
                     output ready);
endinterface

// ===== rtl/front_middle_back_queue_top.sv =====
// Front-middle-back queue of signed words. A request is not taken while the
// previous one executes: the accept cycle reads one word from each half store,
// the next cycle writes back at most one word per half and loads the response
// register. This split is set by the registered read of the half-store rams
// followed by the write of the moved word. The next request is taken only when
// the response register is empty or is read in that same cycle, so a stalled
// response stalls the request side. The queue holds at most
// 2*HALF_DEPTH-1 words; further pushes are dropped with status 2. The stores
// need no clearing after reset, so requests are taken right away.
// depends on fmbq_pkg, fmbq_req_if, fmbq_rsp_if, fmbq_ctrl, fmbq_dp
module front_middle_back_queue_top #(
    parameter int HALF_DEPTH = 512,
    parameter int WORD_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fmbq_req_if.sink   i_req,
    fmbq_rsp_if.source o_rsp
);
    fmbq_pkg::t_dp_cmd cmd;
    logic              in_ready;
    logic              out_valid;

    fmbq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    fmbq_dp #(.HALF_DEPTH(HALF_DEPTH), .WORD_WIDTH(WORD_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_type   (i_req.req_type),
        .i_push_value (i_req.push_value),
        .o_pop_value  (o_rsp.pop_value),
        .o_status     (o_rsp.status),
        .o_item_count (o_rsp.item_count)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
endmodule

// ===== rtl/fmbq_ram.sv =====
// fmbq_ram: generic single write port, single read port ram with registered read
// no dependencies
module fmbq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/fmbq_ctrl.sv =====
// fmbq_ctrl: request sequencer, accepts a word, runs the execute cycle,
// holds the response valid; depends on fmbq_pkg
module fmbq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output fmbq_pkg::t_dp_cmd o_cmd
);
    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic accept;

    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (r_state == S_EXEC) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.exec   = (r_state == S_EXEC);
endmodule

// ===== rtl/fmbq_dp.sv =====
// fmbq_dp: left and right half stores, head and size registers, rebalance
// and result registers; depends on fmbq_pkg and fmbq_ram
module fmbq_dp #(
    parameter int HALF_DEPTH = 512,
    parameter int WORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fmbq_pkg::t_dp_cmd             i_cmd,
    input  logic [fmbq_pkg::REQ_W-1:0]    i_req_type,
    input  logic [fmbq_pkg::VALUE_W-1:0]  i_push_value,
    output logic [fmbq_pkg::VALUE_W-1:0]  o_pop_value,
    output logic [fmbq_pkg::STATUS_W-1:0] o_status,
    output logic [fmbq_pkg::COUNT_W-1:0]  o_item_count
);
    localparam int AW = $clog2(HALF_DEPTH);
    localparam int SW = $clog2(HALF_DEPTH + 1);
    localparam logic [SW:0] CAP = (SW + 1)'(2 * HALF_DEPTH - 1);

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [SW-1:0] off);
        logic [AW+1:0] s;
        s = {2'b00, base} + (AW + 2)'(off);
        if (s >= (AW + 2)'(HALF_DEPTH)) begin
            s = s - (AW + 2)'(HALF_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] base);
        logic [AW-1:0] d;
        d = (base == '0) ? AW'(HALF_DEPTH - 1) : base - AW'(1);
        return d;
    endfunction

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] base);
        logic [AW-1:0] d;
        d = (base == AW'(HALF_DEPTH - 1)) ? '0 : base + AW'(1);
        return d;
    endfunction

    logic [AW-1:0] r_lh, n_lh, r_rh, n_rh;
    logic [SW-1:0] r_ls, n_ls, r_rs, n_rs;

    logic [fmbq_pkg::REQ_W-1:0]    r_req;
    logic [WORD_WIDTH-1:0]         r_val;
    logic [fmbq_pkg::VALUE_W-1:0]  r_pop;
    logic [fmbq_pkg::STATUS_W-1:0] r_status;
    logic [fmbq_pkg::COUNT_W-1:0]  r_count;

    logic [WORD_WIDTH+31:0] push_sx;
    logic [WORD_WIDTH-1:0]  push_word;

    logic [SW-1:0]         l_back_off, r_back_off;
    logic [AW-1:0]         l_raddr, r_raddr;
    logic [WORD_WIDTH-1:0] l_rdata, r_rdata;
    logic                  l_we, r_we;
    logic [AW-1:0]         l_waddr, r_waddr;
    logic [WORD_WIDTH-1:0] l_wdata, r_wdata;

    logic [SW:0]                   count, n_count;
    logic                          full, sizes_eq;
    logic [WORD_WIDTH-1:0]         res_word;
    logic [fmbq_pkg::STATUS_W-1:0] res_status;
    logic [WORD_WIDTH+31:0]        pop_ext;
    logic [SW+fmbq_pkg::COUNT_W:0] count_ext;

    // sign extend the 32-bit field to the word width
    assign push_sx   = {{WORD_WIDTH{i_push_value[fmbq_pkg::VALUE_W-1]}}, i_push_value};
    assign push_word = push_sx[WORD_WIDTH-1:0];

    // read addresses issued on the accept cycle
    assign l_back_off = (r_ls == '0) ? '0 : r_ls - SW'(1);
    assign r_back_off = (r_rs == '0) ? '0 : r_rs - SW'(1);
    assign l_raddr = (i_req_type == fmbq_pkg::REQ_POP_FRONT) ? r_lh
                                                            : wrap_add(r_lh, l_back_off);
    assign r_raddr = (i_req_type == fmbq_pkg::REQ_POP_BACK) ? wrap_add(r_rh, r_back_off)
                                                           : r_rh;

    fmbq_ram #(.WIDTH(WORD_WIDTH), .DEPTH(HALF_DEPTH)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    fmbq_ram #(.WIDTH(WORD_WIDTH), .DEPTH(HALF_DEPTH)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (r_we),
        .i_waddr (r_waddr),
        .i_wdata (r_wdata),
        .i_re    (i_cmd.accept),
        .i_raddr (r_raddr),
        .o_rdata (r_rdata)
    );

    assign count    = {1'b0, r_ls} + {1'b0, r_rs};
    assign full     = (count >= CAP);
    assign sizes_eq = (r_ls == r_rs);

    always_comb begin
        n_lh       = r_lh;
        n_rh       = r_rh;
        n_ls       = r_ls;
        n_rs       = r_rs;
        l_we       = 1'b0;
        l_waddr    = r_lh;
        l_wdata    = r_val;
        r_we       = 1'b0;
        r_waddr    = r_rh;
        r_wdata    = r_val;
        res_word   = '0;
        res_status = fmbq_pkg::STS_OK;
        if (i_cmd.exec) begin
            unique case (r_req)
                fmbq_pkg::REQ_PUSH_FRONT: begin
                    if (full) begin
                        res_status = fmbq_pkg::STS_FULL;
                    end else begin
                        l_we    = 1'b1;
                        l_waddr = wrap_dec(r_lh);
                        n_lh    = l_waddr;
                        if (sizes_eq) begin
                            r_we    = 1'b1;
                            r_waddr = wrap_dec(r_rh);
                            r_wdata = (r_ls == '0) ? r_val : l_rdata;
                            n_rh    = r_waddr;
                            n_rs    = r_rs + SW'(1);
                        end else begin
                            n_ls = r_ls + SW'(1);
                        end
                    end
                end
                fmbq_pkg::REQ_PUSH_MIDDLE: begin
                    if (full) begin
                        res_status = fmbq_pkg::STS_FULL;
                    end else if (sizes_eq) begin
                        r_we    = 1'b1;
                        r_waddr = wrap_dec(r_rh);
                        n_rh    = r_waddr;
                        n_rs    = r_rs + SW'(1);
                    end else begin
                        l_we    = 1'b1;
                        l_waddr = wrap_add(r_lh, r_ls);
                        n_ls    = r_ls + SW'(1);
                    end
                end
                fmbq_pkg::REQ_PUSH_BACK: begin
                    if (full) begin
                        res_status = fmbq_pkg::STS_FULL;
                    end else begin
                        r_we    = 1'b1;
                        r_waddr = wrap_add(r_rh, r_rs);
                        if (sizes_eq) begin
                            n_rs = r_rs + SW'(1);
                        end else begin
                            // right front moves to the left back
                            l_we    = 1'b1;
                            l_waddr = wrap_add(r_lh, r_ls);
                            l_wdata = r_rdata;
                            n_ls    = r_ls + SW'(1);
                            n_rh    = wrap_inc(r_rh);
                        end
                    end
                end
                fmbq_pkg::REQ_POP_FRONT: begin
                    if (r_rs == '0) begin
                        res_word   = '1;
                        res_status = fmbq_pkg::STS_EMPTY;
                    end else if (r_ls == '0) begin
                        res_word = r_rdata;
                        n_rh     = wrap_inc(r_rh);
                        n_rs     = r_rs - SW'(1);
                    end else begin
                        res_word = l_rdata;
                        n_lh     = wrap_inc(r_lh);
                        if (sizes_eq) begin
                            n_ls = r_ls - SW'(1);
                        end else begin
                            l_we    = 1'b1;
                            l_waddr = wrap_add(r_lh, r_ls);
                            l_wdata = r_rdata;
                            n_rh    = wrap_inc(r_rh);
                            n_rs    = r_rs - SW'(1);
                        end
                    end
                end
                fmbq_pkg::REQ_POP_MIDDLE: begin
                    if (r_rs == '0) begin
                        res_word   = '1;
                        res_status = fmbq_pkg::STS_EMPTY;
                    end else if (!sizes_eq) begin
                        res_word = r_rdata;
                        n_rh     = wrap_inc(r_rh);
                        n_rs     = r_rs - SW'(1);
                    end else begin
                        res_word = l_rdata;
                        n_ls     = r_ls - SW'(1);
                    end
                end
                fmbq_pkg::REQ_POP_BACK: begin
                    if (r_rs == '0) begin
                        res_word   = '1;
                        res_status = fmbq_pkg::STS_EMPTY;
                    end else begin
                        res_word = r_rdata;
                        if (sizes_eq) begin
                            // left back moves to the right front
                            r_we    = 1'b1;
                            r_waddr = wrap_dec(r_rh);
                            r_wdata = l_rdata;
                            n_rh    = r_waddr;
                            n_ls    = r_ls - SW'(1);
                        end else begin
                            n_rs = r_rs - SW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign n_count   = {1'b0, n_ls} + {1'b0, n_rs};
    assign pop_ext   = {32'b0, res_word};
    assign count_ext = {{fmbq_pkg::COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lh <= '0;
            r_rh <= '0;
            r_ls <= '0;
            r_rs <= '0;
        end else begin
            r_lh <= n_lh;
            r_rh <= n_rh;
            r_ls <= n_ls;
            r_rs <= n_rs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req_type;
            r_val <= push_word;
        end
        if (i_cmd.exec) begin
            r_pop    <= pop_ext[fmbq_pkg::VALUE_W-1:0];
            r_status <= res_status;
            r_count  <= count_ext[fmbq_pkg::COUNT_W-1:0];
        end
    end

    assign o_pop_value  = r_pop;
    assign o_status     = r_status;
    assign o_item_count = r_count;
endmodule

// ===== rtl/fmbq_checker.sv =====
// fmbq_checker: port level checks of the front-middle-back queue, bound to the top
// depends on fmbq_pkg
module fmbq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic [fmbq_pkg::VALUE_W-1:0]  i_pop_value,
    input logic [fmbq_pkg::STATUS_W-1:0] i_status,
    input logic [fmbq_pkg::COUNT_W-1:0]  i_item_count
);
    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // one request at a time
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !in_acc)
        else $error("request taken in consecutive cycles");

    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 i_out_valid)
        else $error("response missing two cycles after request");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == fmbq_pkg::STS_EMPTY) |->
            (i_item_count == '0 && i_pop_value[0]))
        else $error("empty pop with nonzero count or wrong word");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == fmbq_pkg::STS_FULL) |-> (i_pop_value == '0))
        else $error("dropped push returned a word");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == fmbq_pkg::STS_OK || i_status == fmbq_pkg::STS_EMPTY
                         || i_status == fmbq_pkg::STS_FULL))
        else $error("undefined status code");
endmodule

bind front_middle_back_queue_top fmbq_checker u_fmbq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_pop_value  (o_rsp.pop_value),
    .i_status     (o_rsp.status),
    .i_item_count (o_rsp.item_count)
);
